/* design/block_occupancy_detector_assert.svh */
// Assertion macros shared by the occupancy detector RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BLOCK_OCCUPANCY_DETECTOR_ASSERT_SVH
`define BLOCK_OCCUPANCY_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define BOD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bod_pkg.sv */
`timescale 1ns / 1ps
package bod_pkg;

  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned CH_W      = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned SMOOTH_W  = 16;
  localparam int unsigned MA_W      = 13;
  localparam logic [MA_W-1:0] MA_MAX = MA_W'(5071);

  typedef enum logic [1:0] {
    OP_CAL,
    OP_POWERED,
    OP_IDLE,
    OP_PULSE
  } op_e;

  typedef enum logic [1:0] {
    ST_UNKNOWN,
    ST_CLEAR,
    ST_OCCUPIED
  } blk_st_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCCUPIED,
    CFG_CLEAR,
    CFG_ON_DELAY,
    CFG_OFF_DELAY,
    CFG_CH_EN,
    CFG_PULSE_EN,
    CFG_PULSE_INT
  } cfg_idx_e;

  // What the last stage still has to do with an item.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PASS,
    ACT_SAMPLE
  } act_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         channel;
    logic [COUNT_W-1:0] raw_count;
    logic [31:0]        now_ms;
    logic               pulse_allowed;
    logic               driver_faulted;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      result_channel;
    logic [1:0]      block_state;
    logic            state_changed;
    logic [MA_W-1:0] milliamps;
    logic            pulse_request;
    logic            pulse_stopped;
  } out_item_t;

  // One channel's entry in the state memory.
  typedef struct packed {
    logic [COUNT_W-1:0]  baseline;
    logic [SMOOTH_W-1:0] smoothed;
    blk_st_e             cur_st;
    blk_st_e             want_st;
    logic [31:0]         want_since;
    logic [31:0]         last_pulse;
  } entry_t;

  // Item context carried alongside the milliamp conversion.
  typedef struct packed {
    logic [1:0]  chan;
    act_e        act;
    logic        changed;
    logic        request;
    logic        stopped;
    logic [31:0] now;
    entry_t      ent;
  } ctx_t;

endpackage

/* design/bod_state_mem.sv */
`timescale 1ns / 1ps
module bod_state_mem import bod_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [CH_W-1:0] rd_addr_i,
  output entry_t          rd_data_o,
  input  logic            wr_en_i,
  input  logic [CH_W-1:0] wr_addr_i,
  input  entry_t          wr_data_i
);

  entry_t              mem_q [NUM_CH];
  logic [NUM_CH-1:0]   vld_q;
  entry_t              rd_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // An entry never written since reset reads as the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : entry_t'('0);

endmodule

/* design/bod_ma_conv.sv */
`timescale 1ns / 1ps
module bod_ma_conv import bod_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COUNT_W-1:0] in_counts_i,
  input  ctx_t               in_ctx_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [MA_W-1:0]    out_ma_o,
  output ctx_t               out_ctx_o
);

  // mA = floor(floor(counts * 220000 / 273) * 20 / 13013), each division done
  // as a multiply by a truncated reciprocal followed by a one-step correction.
  localparam int unsigned NSTG   = 5;
  localparam int unsigned X_W    = 30;
  localparam int unsigned Q1_W   = 22;
  localparam int unsigned Y_W    = 26;
  localparam int unsigned SH1    = 39;
  localparam int unsigned SH2    = 40;
  localparam int unsigned RCP1_W = 31;
  localparam int unsigned RCP2_W = 27;
  localparam int unsigned P1_W   = X_W + RCP1_W;
  localparam int unsigned P2_W   = Y_W + RCP2_W;
  localparam longint unsigned UV_MUL = 220000;
  localparam longint unsigned UV_DIV = 273;
  localparam longint unsigned MA_MUL = 20;
  localparam longint unsigned MA_DIV = 13013;
  localparam longint unsigned RCP1   = (64'd1 << SH1) / UV_DIV;
  localparam longint unsigned RCP2   = (64'd1 << SH2) / MA_DIV;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] rdy;
  ctx_t            ctx_q [NSTG];

  logic [X_W-1:0]  x0_d, x0_q, x1_q, r1;
  logic [P1_W-1:0] p1;
  logic [Q1_W-1:0] q1_q, uv;
  logic [Y_W-1:0]  y2_d, y2_q, y3_q, r2;
  logic [P2_W-1:0] p2;
  logic [MA_W-1:0] q3_q, ma_d, ma4_q;

  always_comb begin
    rdy[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    x0_d = X_W'(X_W'(in_counts_i) * X_W'(UV_MUL));
    p1   = P1_W'(x0_q) * P1_W'(RCP1);
    r1   = x1_q - X_W'(X_W'(q1_q) * X_W'(UV_DIV));
    uv   = q1_q + Q1_W'(r1 >= X_W'(UV_DIV));
    y2_d = Y_W'(Y_W'(uv) * Y_W'(MA_MUL));
    p2   = P2_W'(y2_q) * P2_W'(RCP2);
    r2   = y3_q - Y_W'(Y_W'(q3_q) * Y_W'(MA_DIV));
    ma_d = q3_q + MA_W'(r2 >= Y_W'(MA_DIV));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      x0_q     <= x0_d;
      ctx_q[0] <= in_ctx_i;
    end
    if (rdy[1] && v_q[0]) begin
      x1_q     <= x0_q;
      q1_q     <= p1[SH1 +: Q1_W];
      ctx_q[1] <= ctx_q[0];
    end
    if (rdy[2] && v_q[1]) begin
      y2_q     <= y2_d;
      ctx_q[2] <= ctx_q[1];
    end
    if (rdy[3] && v_q[2]) begin
      y3_q     <= y2_q;
      q3_q     <= p2[SH2 +: MA_W];
      ctx_q[3] <= ctx_q[2];
    end
    if (rdy[4] && v_q[3]) begin
      ma4_q    <= ma_d;
      ctx_q[4] <= ctx_q[3];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_ma_o    = ma4_q;
  assign out_ctx_o   = ctx_q[NSTG-1];

endmodule

/* design/block_occupancy_detector.sv */
// Per-channel occupancy detector with hysteresis and debounce.
// Requests enter on in_valid_i/in_ready_o with an in_item_t payload; one result
// per request leaves on out_valid_o/out_ready_i as an out_item_t.
// Thresholds, delays, enables and the pulse interval are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while no request is in flight.
// Path: a request passes through the state read, five conversion stages and
// the output register before its result is valid.
// Throughput: requests to different channels are taken on consecutive cycles
// while the receiver does not stall. Per-channel state sits in a memory with
// a registered read, so a request for a channel whose earlier request is
// still in flight waits until that state is written back.
// Reset: registers take their reset values, every channel is unknown with zero
// baseline, smoothing, timestamps and fault latch. Reset takes effect at once;
// there is no clearing pass.
// When the receiver stalls, the finished result waits in the output register
// and later requests wait in the conversion stages; in_ready_o drops once the
// stages are full or the next request's channel still has a request in flight.
`timescale 1ns / 1ps
module block_occupancy_detector import bod_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [15:0]       occ_q, clr_q, pint_q;
  logic [31:0]       on_q, off_q;
  logic [NUM_CH-1:0] chen_q, pen_q;

  logic [NUM_CH-1:0] fault_q;
  logic [NUM_CH-1:0] pend_q, pend_d;

  // Input side.
  logic            in_range, in_busy, in_fire;
  logic [CH_W-1:0] in_chx;

  // Read stage.
  logic            s1_v_q;
  in_item_t        s1_in_q;
  logic            s1_ready, s1_fire, s1_range;
  logic [CH_W-1:0] s1_chx;
  entry_t          rd_ent;
  ctx_t            s1_ctx;
  logic            fault_nxt, go_unk, smp, w8;
  logic [COUNT_W-1:0]  sub;
  logic [SMOOTH_W-1:0] sm_w4, sm_w8;

  // Conversion pipeline.
  logic            conv_in_ready, conv_out_valid, conv_out_ready;
  logic [MA_W-1:0] conv_ma;
  ctx_t            conv_ctx;

  // Final stage.
  logic            fin_fire;
  entry_t          fin_ent;
  logic            fin_changed;
  logic [15:0]     clr_eff, ma16;
  blk_st_e         want;
  logic [31:0]     elapsed, need;
  out_item_t       out_d, out_q;
  logic            out_v_q;
  logic            mem_wr_en;
  logic [CH_W-1:0] mem_wr_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 16'd5;
      clr_q  <= 16'd3;
      on_q   <= 32'd20;
      off_q  <= 32'd1000;
      chen_q <= '1;
      pen_q  <= '1;
      pint_q <= 16'd300;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OCCUPIED:  occ_q  <= cfg_wdata_i[15:0];
        CFG_CLEAR:     clr_q  <= cfg_wdata_i[15:0];
        CFG_ON_DELAY:  on_q   <= cfg_wdata_i;
        CFG_OFF_DELAY: off_q  <= cfg_wdata_i;
        CFG_CH_EN:     chen_q <= cfg_wdata_i[NUM_CH-1:0];
        CFG_PULSE_EN:  pen_q  <= cfg_wdata_i[NUM_CH-1:0];
        CFG_PULSE_INT: pint_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // A channel with a request in flight blocks further requests to it until
  // its entry has been written back.
  assign in_chx     = in_data_i.channel[CH_W-1:0];
  assign in_range   = 32'(in_data_i.channel) < NUM_CH;
  assign in_busy    = in_range && pend_q[in_chx];
  assign s1_ready   = !s1_v_q || conv_in_ready;
  assign in_ready_o = s1_ready && !in_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_in_q <= in_data_i;
    end
  end

  bod_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire && in_range),
    .rd_addr_i (in_chx),
    .rd_data_o (rd_ent),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (fin_ent)
  );

  assign s1_chx   = s1_in_q.channel[CH_W-1:0];
  assign s1_range = 32'(s1_in_q.channel) < NUM_CH;
  assign s1_fire  = s1_v_q && conv_in_ready;

  always_comb begin
    sub   = (s1_in_q.raw_count > rd_ent.baseline) ?
            s1_in_q.raw_count - rd_ent.baseline : '0;
    sm_w4 = SMOOTH_W'(((18'(rd_ent.smoothed) * 18'd3) >> 2) + (18'(sub) << 2));
    sm_w8 = SMOOTH_W'((18'(rd_ent.smoothed) >> 1) + (18'(sub) << 3));

    s1_ctx         = '0;
    s1_ctx.chan    = s1_in_q.channel;
    s1_ctx.act     = ACT_PASS;
    s1_ctx.now     = s1_in_q.now_ms;
    s1_ctx.ent     = rd_ent;
    fault_nxt      = fault_q[s1_chx];
    go_unk         = 1'b0;
    smp            = 1'b0;
    w8             = 1'b0;

    if (!s1_range) begin
      s1_ctx.act = ACT_NONE;
    end else begin
      case (op_e'(s1_in_q.opcode))
        OP_CAL: begin
          s1_ctx.ent.baseline = s1_in_q.raw_count;
          s1_ctx.ent.smoothed = '0;
        end
        OP_POWERED: begin
          if (!chen_q[s1_chx]) begin
            go_unk = 1'b1;
          end else begin
            fault_nxt = 1'b0;
            smp       = 1'b1;
          end
        end
        OP_IDLE: begin
          if (!chen_q[s1_chx] || !pen_q[s1_chx] || fault_q[s1_chx] ||
              !s1_in_q.pulse_allowed) begin
            go_unk = 1'b1;
          end else if ((s1_in_q.now_ms - rd_ent.last_pulse) >= 32'(pint_q)) begin
            s1_ctx.ent.last_pulse = s1_in_q.now_ms;
            s1_ctx.request        = 1'b1;
          end
        end
        OP_PULSE: begin
          if (!chen_q[s1_chx] || !pen_q[s1_chx] || fault_q[s1_chx]) begin
            go_unk = 1'b1;
          end else if (s1_in_q.driver_faulted) begin
            fault_nxt = 1'b1;
            go_unk    = 1'b1;
          end else begin
            smp = 1'b1;
            w8  = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (go_unk) begin
      s1_ctx.ent.smoothed = '0;
      if (rd_ent.cur_st != ST_UNKNOWN) begin
        s1_ctx.ent.cur_st  = ST_UNKNOWN;
        s1_ctx.ent.want_st = ST_UNKNOWN;
        s1_ctx.changed     = 1'b1;
      end
    end
    if (smp) begin
      s1_ctx.ent.smoothed = w8 ? sm_w8 : sm_w4;
      s1_ctx.act          = ACT_SAMPLE;
    end
    s1_ctx.stopped = fault_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= '0;
    end else if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_PULSE_EN ||
                              cfg_idx_e'(cfg_idx_i) == CFG_PULSE_INT)) begin
      fault_q <= '0;
    end else if (s1_fire && s1_range) begin
      fault_q[s1_chx] <= fault_nxt;
    end
  end

  bod_ma_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_v_q),
    .in_ready_o  (conv_in_ready),
    .in_counts_i (s1_ctx.ent.smoothed[SMOOTH_W-1 -: COUNT_W]),
    .in_ctx_i    (s1_ctx),
    .out_valid_o (conv_out_valid),
    .out_ready_i (conv_out_ready),
    .out_ma_o    (conv_ma),
    .out_ctx_o   (conv_ctx)
  );

  assign conv_out_ready = !out_v_q || out_ready_i;
  assign fin_fire       = conv_out_valid && conv_out_ready;

  // Thresholds with hysteresis, then the on/off debounce.
  always_comb begin
    fin_ent     = conv_ctx.ent;
    fin_changed = conv_ctx.changed;
    ma16        = 16'(conv_ma);
    clr_eff     = clr_q;
    if (clr_q >= occ_q) begin
      clr_eff = (occ_q > 16'd1) ? occ_q - 16'd1 : '0;
    end
    want = conv_ctx.ent.cur_st;
    if (ma16 >= occ_q) begin
      want = ST_OCCUPIED;
    end else if (ma16 < clr_eff) begin
      want = ST_CLEAR;
    end else if (conv_ctx.ent.cur_st == ST_UNKNOWN) begin
      want = ST_CLEAR;
    end
    need    = (want == ST_OCCUPIED) ? on_q : off_q;
    elapsed = conv_ctx.now - conv_ctx.ent.want_since;
    if (want != conv_ctx.ent.want_st) begin
      elapsed = '0;
    end

    if (conv_ctx.act == ACT_SAMPLE) begin
      if (want != conv_ctx.ent.cur_st) begin
        if (want != conv_ctx.ent.want_st) begin
          fin_ent.want_st    = want;
          fin_ent.want_since = conv_ctx.now;
        end
        if (elapsed >= need) begin
          fin_ent.cur_st = want;
          fin_changed    = 1'b1;
        end
      end else begin
        fin_ent.want_st    = want;
        fin_ent.want_since = conv_ctx.now;
      end
    end

    out_d                = '0;
    out_d.result_channel = conv_ctx.chan;
    if (conv_ctx.act != ACT_NONE) begin
      out_d.block_state   = fin_ent.cur_st;
      out_d.state_changed = fin_changed;
      out_d.milliamps     = conv_ma;
      out_d.pulse_request = conv_ctx.request;
      out_d.pulse_stopped = conv_ctx.stopped;
    end
  end

  assign mem_wr_en   = fin_fire && conv_ctx.act != ACT_NONE;
  assign mem_wr_addr = conv_ctx.chan[CH_W-1:0];

  always_comb begin
    pend_d = pend_q;
    if (mem_wr_en) begin
      pend_d[mem_wr_addr] = 1'b0;
    end
    if (in_fire && in_range) begin
      pend_d[in_chx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (conv_out_ready) begin
        out_v_q <= conv_out_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `include "block_occupancy_detector_assert.svh"

  `BOD_ASSERT_NOW(a_wr_pending, mem_wr_en, pend_q[mem_wr_addr], "write-back to an idle channel")
  `BOD_ASSERT_NEXT(a_pend_set, in_fire && in_range, pend_q[$past(in_chx)], "busy bit not set")
  `BOD_ASSERT_NOW(a_req_no_change, out_v_q && out_q.pulse_request, !out_q.state_changed, "request and change")
  `BOD_ASSERT_NOW(a_ma_range, out_v_q, out_q.milliamps <= MA_MAX, "milliamps out of range")

endmodule
